FILE: sv/markup_tag_stripper_assert.svh
// Assertion macros for the markup tag stripper.
`ifndef MARKUP_TAG_STRIPPER_ASSERT_SVH
`define MARKUP_TAG_STRIPPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define MTS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("markup_tag_stripper: check failed");
// Checked on every edge, reset included.
`define MTS_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("markup_tag_stripper: reset check failed");
`else
`define MTS_ASSERT(lbl, prop)
`define MTS_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: sv/mts_pkg.sv
// Shared types and character constants of the markup tag stripper.
`timescale 1ns / 1ps
package mts_pkg;

  localparam int unsigned HIST_DEPTH = 8;

  // Character codes.
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Element markers, oldest byte in the most significant position.
  localparam logic [55:0] OPEN_SCRIPT = "<script";
  localparam logic [47:0] OPEN_STYLE = "<style";
  localparam logic [63:0] CLOSE_SCRIPT = "</script";
  localparam logic [55:0] CLOSE_STYLE = "</style";

  // How the back end treats a classified byte.
  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_SPACE,
    KIND_TEXT
  } kind_t;

  // One queue entry between front and back.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } qent_t;

  // Byte history, index 0 the most recent byte.
  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

endpackage

FILE: sv/mts_front.sv
// Front end: tracks tag and element state and classifies each byte.
`timescale 1ns / 1ps
module mts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_rdy,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_doc,
  input  logic          q_full,
  output logic          q_push,
  output mts_pkg::qent_t q_data
);

  mts_pkg::hist_t hist_r, hist_nxt;
  logic tag_r, tag_nxt;
  logic script_r, script_nxt;
  logic style_r, style_nxt;

  logic open_script_m, open_style_m;
  logic close_script_m, close_style_m;
  logic script_eff, style_eff;
  logic is_ws;
  logic keep;

  assign in_rdy = !q_full;
  assign q_push = in_vld && !q_full;

  // Pattern matches against the previous bytes.
  assign open_script_m  = (hist_r[6:0] == mts_pkg::OPEN_SCRIPT);
  assign open_style_m   = (hist_r[5:0] == mts_pkg::OPEN_STYLE);
  assign close_script_m = (hist_r[7:0] == mts_pkg::CLOSE_SCRIPT);
  assign close_style_m  = (hist_r[6:0] == mts_pkg::CLOSE_STYLE);

  assign script_eff = script_r || open_script_m;
  assign style_eff  = style_r || open_style_m;

  assign is_ws = (in_byte == mts_pkg::CH_SP) || (in_byte == mts_pkg::CH_HT) ||
                 (in_byte == mts_pkg::CH_LF) || (in_byte == mts_pkg::CH_VT) ||
                 (in_byte == mts_pkg::CH_FF) || (in_byte == mts_pkg::CH_CR);

  // Tag and element state update for the incoming byte.
  always_comb begin
    tag_nxt    = tag_r;
    script_nxt = script_eff;
    style_nxt  = style_eff;
    if (in_byte == mts_pkg::CH_LT) begin
      tag_nxt = 1'b1;
    end else if (in_byte == mts_pkg::CH_GT) begin
      if (script_eff && close_script_m) begin
        script_nxt = 1'b0;
      end
      if (style_eff && close_style_m) begin
        style_nxt = 1'b0;
      end
      tag_nxt = 1'b0;
    end
  end

  assign keep = (in_byte != mts_pkg::CH_GT) && !tag_nxt && !script_nxt && !style_nxt;

  // Classification of the beat for the back end.
  always_comb begin
    q_data.data = in_byte;
    q_data.last = in_end_of_doc;
    if (!keep) begin
      q_data.kind = mts_pkg::KIND_DROP;
    end else if (is_ws) begin
      q_data.kind = mts_pkg::KIND_SPACE;
    end else begin
      q_data.kind = mts_pkg::KIND_TEXT;
    end
  end

  // History shift.
  always_comb begin
    hist_nxt = {hist_r[mts_pkg::HIST_DEPTH-2:0], in_byte};
  end

  // State registers; the last byte of a document clears everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      tag_r    <= 1'b0;
      script_r <= 1'b0;
      style_r  <= 1'b0;
    end else if (q_push) begin
      if (in_end_of_doc) begin
        hist_r   <= '0;
        tag_r    <= 1'b0;
        script_r <= 1'b0;
        style_r  <= 1'b0;
      end else begin
        hist_r   <= hist_nxt;
        tag_r    <= tag_nxt;
        script_r <= script_nxt;
        style_r  <= style_nxt;
      end
    end
  end

endmodule

FILE: sv/mts_queue.sv
// Short queue of classified beats between front and back end.
`timescale 1ns / 1ps
module mts_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mts_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output mts_pkg::qent_t pop_data,
  output logic           empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mts_pkg::qent_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/mts_back.sv
// Back end: whitespace collapse and the output register.
`timescale 1ns / 1ps
module mts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mts_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_vld,
  input  logic           out_rdy,
  output logic [7:0]     out_byte,
  output logic           out_valid,
  output logic           out_last
);

  logic       out_vld_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_last_r;
  logic       emitted_r, emitted_nxt;
  logic       space_r, space_nxt;

  assign q_pop     = !q_empty && (!out_vld_r || out_rdy);
  assign out_vld   = out_vld_r;
  assign out_byte  = out_byte_r;
  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;

  // Emit decision for the popped beat.
  always_comb begin
    out_byte_nxt  = mts_pkg::CH_NUL;
    out_valid_nxt = 1'b0;
    emitted_nxt   = emitted_r;
    space_nxt     = space_r;
    unique case (q_data.kind)
      mts_pkg::KIND_SPACE: begin
        if (emitted_r && !space_r) begin
          out_byte_nxt  = mts_pkg::CH_SP;
          out_valid_nxt = 1'b1;
          space_nxt     = 1'b1;
        end
      end
      mts_pkg::KIND_TEXT: begin
        out_byte_nxt  = q_data.data;
        out_valid_nxt = 1'b1;
        emitted_nxt   = 1'b1;
        space_nxt     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Collapse state, cleared after the last byte of a document.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitted_r <= 1'b0;
      space_r   <= 1'b0;
    end else if (q_pop) begin
      emitted_r <= q_data.last ? 1'b0 : emitted_nxt;
      space_r   <= q_data.last ? 1'b0 : space_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (q_pop) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte_r  <= out_byte_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= q_data.last;
    end
  end

endmodule

FILE: sv/markup_tag_stripper.sv
// Path: an accepted beat is written to the queue, then popped into the output register.
// Throughput: one byte per cycle while in_rdy is high; the front state update for each
// byte and the back end's whitespace state are each computed combinationally.
// The queue between front and back absorbs output stalls before in_rdy drops.
// Reset: synchronous active-low rst_n clears history, tag state and output valid.
`timescale 1ns / 1ps
`include "markup_tag_stripper_assert.svh"
module markup_tag_stripper #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  output logic       in_rdy,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_doc,
  output logic       out_vld,
  input  logic       out_rdy,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  mts_pkg::qent_t push_data, pop_data;
  logic q_push, q_pop, q_full, q_empty;

  // Classification stage.
  mts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (in_vld),
    .in_rdy        (in_rdy),
    .in_byte       (in_byte),
    .in_end_of_doc (in_end_of_doc),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  // Decoupling queue.
  mts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Emit stage.
  mts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_vld   (out_vld),
    .out_rdy   (out_rdy),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  // A reset cycle leaves no beat pending at the output.
  `MTS_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_vld)
  // A closing bracket is never emitted as text.
  `MTS_ASSERT(a_no_gt_out, out_vld && out_valid |-> out_byte != mts_pkg::CH_GT)
  // A beat without a character carries a zero byte.
  `MTS_ASSERT(a_empty_zero, out_vld && !out_valid |-> out_byte == mts_pkg::CH_NUL)
  // A popped beat never comes from an empty queue.
  `MTS_ASSERT(a_pop_nonempty, q_pop |-> !q_empty)

endmodule
